[src/cau_pkg.sv]
// Shared definitions for the complex arithmetic unit: operation codes,
// default word format and the control word that travels down the pipeline.
// No dependencies.
package cau_pkg;

  // Default word format: signed Q16.16.
  localparam int WordBitsDef = 32;
  localparam int FracBitsDef = 16;

  // Operation codes carried in the kind field.
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_CONJ = 3'd4;

  // Per-item control that rides along with the lane data.
  typedef struct packed {
    logic is_div;
    logic dz;
  } ctl_t;

endpackage

[src/cau_front.sv]
// Front end of the complex arithmetic unit: products, sums and operand
// preparation over three register stages. Depends on cau_pkg.
module cau_front #(
  parameter int WordBits = cau_pkg::WordBitsDef,
  parameter int FracBits = cau_pkg::FracBitsDef
) (
  input  logic                               clk_i,
  input  logic [2:0]                         en_i,
  input  logic [2:0]                         kind_i,
  input  logic signed [WordBits-1:0]         a_re_i,
  input  logic signed [WordBits-1:0]         a_im_i,
  input  logic signed [WordBits-1:0]         b_re_i,
  input  logic signed [WordBits-1:0]         b_im_i,
  output cau_pkg::ctl_t                      ctl_o,
  output logic [1:0]                         neg_o,
  output logic [1:0]                         big_o,
  output logic [1:0][WordBits:0]             mag_o,
  output logic [1:0][2*WordBits-1:0]         rem_o,
  output logic [1:0][WordBits-1:0]           x_o,
  output logic [2*WordBits-1:0]              den_o
);
  import cau_pkg::*;

  localparam int W  = WordBits;
  localparam int PW = 2 * WordBits;
  localparam int NW = 2 * WordBits + FracBits;

  // Stage 0: the six products and the results of the simple operations.
  logic [2:0]            op0_q;
  logic                  dz0_q;
  logic signed [PW-1:0]  p_rr_q, p_ii_q, p_ri_q, p_ir_q, d_r_q, d_i_q;
  logic [1:0][W:0]       s0_q;
  logic [1:0][W:0]       s0_d;

  always_comb begin
    s0_d = '0;
    case (kind_i)
      OP_ADD: begin
        s0_d[0] = {a_re_i[W-1], a_re_i} + {b_re_i[W-1], b_re_i};
        s0_d[1] = {a_im_i[W-1], a_im_i} + {b_im_i[W-1], b_im_i};
      end
      OP_SUB: begin
        s0_d[0] = {a_re_i[W-1], a_re_i} - {b_re_i[W-1], b_re_i};
        s0_d[1] = {a_im_i[W-1], a_im_i} - {b_im_i[W-1], b_im_i};
      end
      OP_CONJ: begin
        s0_d[0] = {a_re_i[W-1], a_re_i};
        s0_d[1] = {(W+1){1'b0}} - {a_im_i[W-1], a_im_i};
      end
      default: begin
        s0_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      op0_q  <= kind_i;
      dz0_q  <= (kind_i == OP_DIV) && (b_re_i == '0) && (b_im_i == '0);
      p_rr_q <= a_re_i * b_re_i;
      p_ii_q <= a_im_i * b_im_i;
      p_ri_q <= a_re_i * b_im_i;
      p_ir_q <= a_im_i * b_re_i;
      d_r_q  <= b_re_i * b_re_i;
      d_i_q  <= b_im_i * b_im_i;
      s0_q   <= s0_d;
    end
  end

  // Stage 1: numerators of multiply or divide and the squared magnitude of B.
  logic [2:0]        op1_q;
  logic              dz1_q;
  logic [1:0][W:0]   s1_q;
  logic [1:0][PW:0]  n1_q;
  logic [PW-1:0]     den1_q;
  logic [1:0][PW:0]  n1_d;
  logic [PW:0]       e_rr, e_ii, e_ri, e_ir;

  always_comb begin
    e_rr = {p_rr_q[PW-1], p_rr_q};
    e_ii = {p_ii_q[PW-1], p_ii_q};
    e_ri = {p_ri_q[PW-1], p_ri_q};
    e_ir = {p_ir_q[PW-1], p_ir_q};
    if (op0_q == OP_MUL) begin
      n1_d[0] = e_rr - e_ii;
      n1_d[1] = e_ri + e_ir;
    end else begin
      n1_d[0] = e_rr + e_ii;
      n1_d[1] = e_ir - e_ri;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      op1_q  <= op0_q;
      dz1_q  <= dz0_q;
      s1_q   <= s0_q;
      n1_q   <= n1_d;
      den1_q <= $unsigned(d_r_q) + $unsigned(d_i_q);
    end
  end

  // Stage 2: sign and magnitude per lane, scaling of the product, and the
  // first partial remainder and range check of the quotient.
  logic [1:0]         neg_d, big_d;
  logic [1:0][W:0]    mag_d;
  logic [1:0][PW-1:0] rem_d;
  logic [1:0][W-1:0]  x_d;
  logic [PW:0]        nneg_t;
  logic [PW-1:0]      nmag, mm;
  logic [NW-1:0]      np, hi;
  logic [W:0]         sneg_t;

  always_comb begin
    neg_d  = '0;
    big_d  = '0;
    mag_d  = '0;
    rem_d  = '0;
    x_d    = '0;
    nneg_t = '0;
    nmag   = '0;
    mm     = '0;
    np     = '0;
    hi     = '0;
    sneg_t = '0;
    for (int i = 0; i < 2; i++) begin
      nneg_t = ~n1_q[i] + {{PW{1'b0}}, 1'b1};
      nmag   = n1_q[i][PW] ? nneg_t[PW-1:0] : n1_q[i][PW-1:0];
      mm     = nmag >> FracBits;
      np     = {nmag, {FracBits{1'b0}}};
      hi     = np >> W;
      sneg_t = ~s1_q[i] + {{W{1'b0}}, 1'b1};
      case (op1_q)
        OP_MUL: begin
          neg_d[i] = n1_q[i][PW];
          mag_d[i] = mm[W:0];
          big_d[i] = |mm[PW-1:W+1];
        end
        OP_DIV: begin
          neg_d[i] = n1_q[i][PW];
          big_d[i] = hi >= {{FracBits{1'b0}}, den1_q};
          rem_d[i] = hi[PW-1:0];
          x_d[i]   = np[W-1:0];
        end
        default: begin
          neg_d[i] = s1_q[i][W];
          mag_d[i] = s1_q[i][W] ? sneg_t : s1_q[i];
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      ctl_o.is_div <= (op1_q == OP_DIV);
      ctl_o.dz     <= dz1_q;
      neg_o        <= neg_d;
      big_o        <= big_d;
      mag_o        <= mag_d;
      rem_o        <= rem_d;
      x_o          <= x_d;
      den_o        <= den1_q;
    end
  end

endmodule

[src/cau_div_step.sv]
// One restoring-division step for both lanes of the complex arithmetic unit,
// with its own register stage. Depends on cau_pkg.
module cau_div_step #(
  parameter int WordBits = cau_pkg::WordBitsDef
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  cau_pkg::ctl_t              ctl_i,
  input  logic [1:0]                 neg_i,
  input  logic [1:0]                 big_i,
  input  logic [1:0][WordBits:0]     mag_i,
  input  logic [1:0][2*WordBits-1:0] rem_i,
  input  logic [1:0][WordBits-1:0]   x_i,
  input  logic [2*WordBits-1:0]      den_i,
  output cau_pkg::ctl_t              ctl_o,
  output logic [1:0]                 neg_o,
  output logic [1:0]                 big_o,
  output logic [1:0][WordBits:0]     mag_o,
  output logic [1:0][2*WordBits-1:0] rem_o,
  output logic [1:0][WordBits-1:0]   x_o,
  output logic [2*WordBits-1:0]      den_o
);
  import cau_pkg::*;

  localparam int W  = WordBits;
  localparam int PW = 2 * WordBits;

  // The next dividend bit leaves the top of x and the quotient bit enters
  // at the bottom, so after all steps x holds the quotient.
  logic [1:0][PW-1:0] rem_d;
  logic [1:0][W-1:0]  x_d;
  logic [PW-1:0]      r;
  logic [PW:0]        diff;

  always_comb begin
    rem_d = '0;
    x_d   = '0;
    r     = '0;
    diff  = '0;
    for (int i = 0; i < 2; i++) begin
      r        = {rem_i[i][PW-2:0], x_i[i][W-1]};
      diff     = {1'b0, r} - {1'b0, den_i};
      rem_d[i] = diff[PW] ? r : diff[PW-1:0];
      x_d[i]   = {x_i[i][W-2:0], ~diff[PW]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_o <= ctl_i;
      neg_o <= neg_i;
      big_o <= big_i;
      mag_o <= mag_i;
      rem_o <= rem_d;
      x_o   <= x_d;
      den_o <= den_i;
    end
  end

endmodule

[src/complex_arithmetic_unit.sv]
// Complex arithmetic unit: add, subtract, multiply, divide and conjugate on
// signed fixed-point complex operands. Uses cau_pkg, cau_front, cau_div_step.
//
// Usage: the input channel (valid_i, stall_o) carries kind and operands A and
// B; the output channel (valid_o, stall_i) carries the saturated result with
// its divide-by-zero and overflow flags. An item moves at a clock edge where
// valid is high and stall is low.
// The path has three front stages for the products, the sums and the operand
// preparation, one stage per quotient bit of the restoring divider, and the
// output register. Every item takes the full path, so results leave in order.
// Throughput is one item per cycle while the receiver does not stall; each
// stage has its own valid bit and takes a new item whenever it is empty or
// its content moves on, so bubbles close up while the receiver stalls. The
// pipeline holds up to WordBits + 4 items before stall_o rises.
// Reset clears all valid bits; the data registers are not reset.
// While stall_i is high the output item holds steady.
module complex_arithmetic_unit #(
  parameter int WordBits = cau_pkg::WordBitsDef,
  parameter int FracBits = cau_pkg::FracBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       stall_o,
  input  logic [2:0]                 kind_i,
  input  logic signed [WordBits-1:0] a_re_i,
  input  logic signed [WordBits-1:0] a_im_i,
  input  logic signed [WordBits-1:0] b_re_i,
  input  logic signed [WordBits-1:0] b_im_i,
  output logic                       valid_o,
  input  logic                       stall_i,
  output logic signed [WordBits-1:0] res_re_o,
  output logic signed [WordBits-1:0] res_im_o,
  output logic                       div_zero_o,
  output logic                       overflow_o
);
  import cau_pkg::*;

  localparam int W  = WordBits;
  localparam int PW = 2 * WordBits;
  localparam int NS = WordBits + 4;

  // Stage valid bits and the ready chain from the output backward.
  logic [NS-1:0] v_q, v_d, rdy;

  assign rdy[NS-1] = ~v_q[NS-1] | ~stall_i;
  for (genvar k = 0; k < NS - 1; k++) begin : g_rdy
    assign rdy[k] = ~v_q[k] | rdy[k+1];
  end

  always_comb begin
    v_d[0] = rdy[0] ? valid_i : v_q[0];
    for (int k = 1; k < NS; k++) begin
      v_d[k] = rdy[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign stall_o = ~rdy[0];
  assign valid_o = v_q[NS-1];

  // Lane data between the stages; index 0 is the front end's output.
  ctl_t                    ctl_s [W+1];
  logic [W:0][1:0]         neg_s, big_s;
  logic [W:0][1:0][W:0]    mag_s;
  logic [W:0][1:0][PW-1:0] rem_s;
  logic [W:0][1:0][W-1:0]  x_s;
  logic [W:0][PW-1:0]      den_s;

  cau_front #(
    .WordBits (WordBits),
    .FracBits (FracBits)
  ) u_front (
    .clk_i  (clk_i),
    .en_i   (rdy[2:0]),
    .kind_i (kind_i),
    .a_re_i (a_re_i),
    .a_im_i (a_im_i),
    .b_re_i (b_re_i),
    .b_im_i (b_im_i),
    .ctl_o  (ctl_s[0]),
    .neg_o  (neg_s[0]),
    .big_o  (big_s[0]),
    .mag_o  (mag_s[0]),
    .rem_o  (rem_s[0]),
    .x_o    (x_s[0]),
    .den_o  (den_s[0])
  );

  // One divider step per quotient bit.
  for (genvar i = 0; i < W; i++) begin : g_step
    cau_div_step #(
      .WordBits (WordBits)
    ) u_step (
      .clk_i (clk_i),
      .en_i  (rdy[3+i]),
      .ctl_i (ctl_s[i]),
      .neg_i (neg_s[i]),
      .big_i (big_s[i]),
      .mag_i (mag_s[i]),
      .rem_i (rem_s[i]),
      .x_i   (x_s[i]),
      .den_i (den_s[i]),
      .ctl_o (ctl_s[i+1]),
      .neg_o (neg_s[i+1]),
      .big_o (big_s[i+1]),
      .mag_o (mag_s[i+1]),
      .rem_o (rem_s[i+1]),
      .x_o   (x_s[i+1]),
      .den_o (den_s[i+1])
    );
  end

  // Saturation, sign and flags for the output register.
  logic [1:0][W-1:0] val_d;
  logic [1:0]        ov_d;
  logic [W:0]        msel, lim, mneg;

  always_comb begin
    val_d = '0;
    ov_d  = '0;
    msel  = '0;
    lim   = '0;
    mneg  = '0;
    for (int i = 0; i < 2; i++) begin
      msel = ctl_s[W].is_div ? {1'b0, x_s[W][i]} : mag_s[W][i];
      lim  = neg_s[W][i] ? {2'b01, {(W-1){1'b0}}} : {2'b00, {(W-1){1'b1}}};
      mneg = ~msel + {{W{1'b0}}, 1'b1};
      ov_d[i] = big_s[W][i] | (msel > lim);
      if (ov_d[i]) begin
        val_d[i] = neg_s[W][i] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
        val_d[i] = neg_s[W][i] ? mneg[W-1:0] : msel[W-1:0];
      end
      if (ctl_s[W].dz) begin
        val_d[i] = '0;
        ov_d[i]  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NS-1]) begin
      res_re_o   <= val_d[0];
      res_im_o   <= val_d[1];
      div_zero_o <= ctl_s[W].dz;
      overflow_o <= |ov_d;
    end
  end

endmodule

[test/tb_top.sv]
// Self-checking testbench for complex_arithmetic_unit: directed and random
// complex operations, predicted in wide integer arithmetic and compared in
// order. Depends on cau_pkg and the RTL under src.
module tb_top;
  import cau_pkg::*;

  // Expected result of one item.
  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               dz;
    logic               ov;
  } cplx_res_t;

  // Clamp a wide value to the signed word range, noting saturation.
  function automatic logic signed [31:0] clamp_word(input logic signed [127:0] v,
                                                    inout logic ov);
    if (v > 128'sd2147483647) begin
      ov = 1'b1;
      return 32'sh7fffffff;
    end else if (v < -128'sd2147483648) begin
      ov = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Work out the result of one operation with every intermediate held exactly.
  function automatic cplx_res_t complex_result(input logic [2:0] kind,
                                               input logic signed [31:0] ar_w,
                                               input logic signed [31:0] ai_w,
                                               input logic signed [31:0] br_w,
                                               input logic signed [31:0] bi_w);
    cplx_res_t r;
    logic signed [127:0] ar, ai, br, bi, re, im, den;
    logic ov;
    ar = ar_w;
    ai = ai_w;
    br = br_w;
    bi = bi_w;
    re = 0;
    im = 0;
    ov = 1'b0;
    r.dz = 1'b0;
    case (kind)
      OP_ADD: begin
        re = ar + br;
        im = ai + bi;
      end
      OP_SUB: begin
        re = ar - br;
        im = ai - bi;
      end
      OP_MUL: begin
        // Signed division truncates toward zero, as the fraction drop does.
        re = (ar * br - ai * bi) / 128'sd65536;
        im = (ar * bi + ai * br) / 128'sd65536;
      end
      OP_DIV: begin
        if (br == 0 && bi == 0) begin
          r.dz = 1'b1;
        end else begin
          den = br * br + bi * bi;
          re = ((ar * br + ai * bi) * 128'sd65536) / den;
          im = ((ai * br - ar * bi) * 128'sd65536) / den;
        end
      end
      OP_CONJ: begin
        re = ar;
        im = -ai;
      end
      default: begin
      end
    endcase
    r.re = clamp_word(re, ov);
    r.im = clamp_word(im, ov);
    r.ov = ov;
    return r;
  endfunction

  // In-order store of expected results and their comparison.
  class result_ledger;
    cplx_res_t expected_q[$];
    int errors = 0;

    function void note_operands(logic [2:0] kind, logic signed [31:0] ar,
                                logic signed [31:0] ai, logic signed [31:0] br,
                                logic signed [31:0] bi);
      expected_q.push_back(complex_result(kind, ar, ai, br, bi));
    endfunction

    function void check_result(logic signed [31:0] re, logic signed [31:0] im,
                               logic dz, logic ov);
      cplx_res_t e;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: re=%0d im=%0d", re, im);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (re !== e.re) begin
        $error("res_re expected %0d got %0d", e.re, re);
        errors++;
      end
      if (im !== e.im) begin
        $error("res_im expected %0d got %0d", e.im, im);
        errors++;
      end
      if (dz !== e.dz) begin
        $error("div_zero expected %0b got %0b", e.dz, dz);
        errors++;
      end
      if (ov !== e.ov) begin
        $error("overflow expected %0b got %0b", e.ov, ov);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               valid_i = 1'b0;
  logic               stall_o;
  logic [2:0]         kind_i = '0;
  logic signed [31:0] a_re_i = '0;
  logic signed [31:0] a_im_i = '0;
  logic signed [31:0] b_re_i = '0;
  logic signed [31:0] b_im_i = '0;
  logic               valid_o;
  logic               stall_i = 1'b0;
  logic signed [31:0] res_re_o;
  logic signed [31:0] res_im_o;
  logic               div_zero_o;
  logic               overflow_o;

  result_ledger ledger = new();
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int stuck_cycles = 0;

  localparam int StuckLimit = 5000;
  localparam int HoldCycles = 300;

  complex_arithmetic_unit dut (.*);

  // Clock with a 12-unit period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Receiver stall: rare random stalls, plus one long hold-off on request.
  initial begin : receiver
    int n;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_i <= 1'b1;
        for (n = 1; n < HoldCycles; n++) @(posedge clk_i);
      end else begin
        stall_i <= !quiet && ($urandom_range(99) < 6);
      end
    end
  end

  // Output acceptance is decided at the falling edge, where inputs are stable.
  always @(negedge clk_i) begin
    if (rst_ni && valid_o && !stall_i)
      ledger.check_result(res_re_o, res_im_o, div_zero_o, overflow_o);
  end

  // Watchdog on cycles in which nothing moves.
  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= StuckLimit) begin
        $display("[complex_arithmetic_unit] ERROR");
        $finish;
      end
    end
  end

  // Offer one item, with an occasional idle cycle first, until it is taken.
  task automatic send_item(input logic [2:0] kind, input logic [31:0] ar,
                           input logic [31:0] ai, input logic [31:0] br,
                           input logic [31:0] bi);
    bit taken;
    while (!quiet && $urandom_range(99) < 6) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    kind_i <= kind;
    a_re_i <= ar;
    a_im_i <= ai;
    b_re_i <= br;
    b_im_i <= bi;
    do begin
      @(negedge clk_i);
      taken = !stall_o;
      @(posedge clk_i);
    end while (!taken);
    ledger.note_operands(kind, ar, ai, br, bi);
  endtask

  // Operand value: full range, small magnitudes, or extremes.
  function automatic logic [31:0] pick_word();
    int sel;
    sel = $urandom_range(9);
    if (sel < 4) return $urandom();
    if (sel < 8) return $urandom_range(32'h0008_0000) - 32'h0004_0000;
    case ($urandom_range(4))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'h0000_0001;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  initial begin : stimulus
    logic [2:0] kind;
    logic [31:0] br, bi;
    int i;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every operation, saturation at both bounds, divide by zero,
    // conjugate of the most negative imaginary part and the unused codes.
    send_item(OP_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_item(OP_ADD, 32'h0001_0000, 32'hffff_0000, 32'h0002_8000, 32'h0000_4000);
    send_item(OP_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    send_item(OP_SUB, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 32'h0003_0000);
    send_item(OP_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hffff_0000);
    send_item(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(OP_MUL, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_item(OP_MUL, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0001, 32'h0000_0001);
    send_item(OP_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0000_0000, 32'h0000_0000);
    send_item(OP_DIV, 32'h0006_0000, 32'h0004_0000, 32'h0002_0000, 32'h0000_0000);
    send_item(OP_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000);
    send_item(OP_DIV, 32'hffff_ffff, 32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000);
    send_item(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(OP_DIV, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'hffff_ffff);
    send_item(OP_CONJ, 32'h8000_0000, 32'h8000_0000, 32'h1234_5678, 32'h9abc_def0);
    send_item(OP_CONJ, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 32'h0);
    send_item(3'd5, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 32'h4444_4444);
    send_item(3'd6, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_item(3'd7, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);

    // Random: mostly valid operations with varied operands.
    for (i = 0; i < 950; i++) begin
      if (i == 250) hold_req = 1'b1;
      quiet = (i >= 500 && i < 700);
      if (i == 800) begin
        // Let the pipeline drain completely before going on.
        valid_i <= 1'b0;
        while (ledger.expected_q.size() > 0) @(posedge clk_i);
      end
      kind = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) :
             3'($urandom_range(4));
      br = pick_word();
      bi = pick_word();
      if (kind == OP_DIV && $urandom_range(9) == 0) begin
        br = '0;
        bi = '0;
      end
      send_item(kind, pick_word(), pick_word(), br, bi);
    end
    valid_i <= 1'b0;
    quiet = 1'b0;

    while (ledger.expected_q.size() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (ledger.errors == 0 && ledger.expected_q.size() == 0) begin
      $display("[complex_arithmetic_unit] OK");
    end else begin
      $display("[complex_arithmetic_unit] ERROR");
    end
    $finish;
  end

endmodule
